@@ hw/rtl/mwee_pkg.sv @@
// Shared types, constants and helpers for the Microwire EEPROM master.
// No dependencies; used by microwire_eeprom_master and its bench.

package mwee_pkg;

    localparam int ADDRESS_BITS_MAX_DEFAULT = 11;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHIP_KIND     = 2'd0,
        REG_WORD_MODE     = 2'd1,
        REG_READY_TIMEOUT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CHIP_93C46   = 2'd0,
        CHIP_93C56   = 2'd1,
        CHIP_93C57   = 2'd2,
        CHIP_93C76   = 2'd3
    } chip_kind_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_code_t;

    localparam logic [13:0] READY_TIMEOUT_RESET = 14'd10000;

    localparam logic [2:0] HDR_READ  = 3'b110;
    localparam logic [2:0] HDR_WRITE = 3'b101;

    // Address bit count of each device family; x8 needs one more bit.
    function automatic logic [3:0] addr_width(input logic [1:0] kind, input logic x16);
        logic [3:0] w;
        case (kind)
            CHIP_93C46: w = 4'd6;
            CHIP_93C56: w = 4'd8;
            CHIP_93C57: w = 4'd7;
            default:    w = 4'd10;
        endcase
        return x16 ? w : w + 4'd1;
    endfunction

endpackage

@@ hw/rtl/microwire_eeprom_master.sv @@
// Microwire master for 93Cxx serial EEPROMs, one handshake word per serial bit time.
// Depends on mwee_pkg for the operation codes, register indexes and address widths.
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+--------------------------------------
//  s_       | in        | s_valid / s_ready  | operation, address, write data, pin in
//  m_       | out       | m_valid / m_ready  | pin levels, status, read word
//  cfg_     | in        | cfg_wr_en          | chip kind, word mode, ready timeout
//
// Each input word yields one output word in the cycle after it is accepted.
// A new word is taken every cycle while the output register is empty or being drained.
// The frame state and the output word sit in one register stage, so the rate is
// one word per cycle while the output is not stalled.
// Reset (synchronous, active low) returns to idle with the registers at their reset values.
// A stalled output holds its word and blocks further input until it is taken.

module microwire_eeprom_master #(
    parameter int ADDRESS_BITS_MAX = mwee_pkg::ADDRESS_BITS_MAX_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [mwee_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mwee_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_operation,
    input  logic [10:0]                     s_address,
    input  logic [15:0]                     s_write_data,
    input  logic                            s_serial_in,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_chip_select,
    output logic                            m_clock_pulse,
    output logic                            m_data_bit,
    output logic                            m_org_select,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic [15:0]                     m_read_data,
    output logic                            m_timed_out
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_EWEN,
        PH_GAP,
        PH_SEND,
        PH_RECV,
        PH_DROP,
        PH_POLL
    } phase_t;

    localparam logic [3:0] ADDR_CLAMP = 4'(ADDRESS_BITS_MAX);

    // Configuration registers.
    logic [1:0]  chip_kind_reg;
    logic        word_mode_reg;
    logic [13:0] ready_timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_kind_reg     <= 2'd0;
            word_mode_reg     <= 1'b1;
            ready_timeout_reg <= mwee_pkg::READY_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mwee_pkg::REG_CHIP_KIND:     chip_kind_reg     <= cfg_wdata[1:0];
                mwee_pkg::REG_WORD_MODE:     word_mode_reg     <= cfg_wdata[0];
                mwee_pkg::REG_READY_TIMEOUT: ready_timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame state and output register.
    phase_t      phase_reg, phase_next;
    logic [5:0]  bit_cnt_reg, bit_cnt_next;
    logic [31:0] frame_reg, frame_next;
    logic [15:0] rx_shift_reg, rx_shift_next;
    logic [13:0] poll_cnt_reg, poll_cnt_next;
    logic        pend_wr_reg, pend_wr_next;

    logic        m_valid_reg;
    logic        cs_reg, cs_next;
    logic        clk_reg, clk_next;
    logic        di_reg, di_next;
    logic        org_reg;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        tmo_reg, tmo_next;

    logic [3:0]  addr_w;
    logic [4:0]  data_w;
    logic [5:0]  frame_len;
    logic [10:0] word_addr;
    logic [15:0] data_val;
    logic [4:0]  addr_shift;
    logic [4:0]  data_shift;
    logic [31:0] start_frame;
    logic        start_rd;
    logic        start_wr;
    logic        accept;
    logic [13:0] poll_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        addr_w = mwee_pkg::addr_width(chip_kind_reg, word_mode_reg);
        if (addr_w > ADDR_CLAMP) begin
            addr_w = ADDR_CLAMP;
        end
    end

    assign data_w    = word_mode_reg ? 5'd16 : 5'd8;
    assign frame_len = 6'd3 + {2'd0, addr_w} + {1'b0, data_w};

    assign start_rd = (phase_reg == PH_IDLE) && (s_operation == mwee_pkg::OP_READ);
    assign start_wr = (phase_reg == PH_IDLE) && (s_operation == mwee_pkg::OP_WRITE);

    // The frame is built left-aligned: header, word address, then data for a write.
    assign word_addr  = (word_mode_reg ? {1'b0, s_address[10:1]} : s_address)
                        & ~(11'h7FF << addr_w);
    assign data_val   = word_mode_reg ? s_write_data : {8'd0, s_write_data[7:0]};
    assign addr_shift = 5'd29 - {1'b0, addr_w};
    assign data_shift = addr_shift - data_w;

    assign start_frame = {(start_rd ? mwee_pkg::HDR_READ : mwee_pkg::HDR_WRITE), 29'd0}
                       | ({21'd0, word_addr} << addr_shift)
                       | (start_wr ? ({16'd0, data_val} << data_shift) : 32'd0);

    assign poll_inc = poll_cnt_reg + 14'd1;

    always_comb begin
        phase_t     ph;
        logic [5:0] bc;
        ph            = phase_reg;
        bc            = bit_cnt_reg;
        frame_next    = frame_reg;
        rx_shift_next = rx_shift_reg;
        poll_cnt_next = poll_cnt_reg;
        pend_wr_next  = pend_wr_reg;
        cs_next       = 1'b0;
        clk_next      = 1'b0;
        di_next       = 1'b0;
        busy_next     = 1'b0;
        done_next     = 1'b0;
        tmo_next      = 1'b0;

        // A start sets up the frame and its first bit (for a write, the write-enable bit) goes out in the same tick.
        if (start_rd) begin
            ph            = PH_SEND;
            bc            = 6'd3 + {2'd0, addr_w};
            frame_next    = start_frame;
            rx_shift_next = 16'd0;
            pend_wr_next  = 1'b0;
        end else if (start_wr) begin
            ph           = PH_EWEN;
            bc           = 6'd0;
            frame_next   = start_frame;
            pend_wr_next = 1'b1;
        end

        phase_next   = ph;
        bit_cnt_next = bc;

        unique case (ph)
            PH_EWEN: begin
                // Write-enable frame: 1, 00, 11, then zeros.
                cs_next   = 1'b1;
                clk_next  = 1'b1;
                busy_next = 1'b1;
                di_next   = (bc == 6'd0) || (bc == 6'd3) || (bc == 6'd4);
                if (bc + 6'd1 >= 6'd3 + {2'd0, addr_w}) begin
                    phase_next   = PH_GAP;
                    bit_cnt_next = 6'd0;
                end else begin
                    bit_cnt_next = bc + 6'd1;
                end
            end
            PH_GAP: begin
                busy_next    = 1'b1;
                phase_next   = PH_SEND;
                bit_cnt_next = frame_len;
            end
            PH_SEND: begin
                cs_next    = 1'b1;
                clk_next   = 1'b1;
                busy_next  = 1'b1;
                di_next    = frame_next[31];
                frame_next = {frame_next[30:0], 1'b0};
                if (bc <= 6'd1) begin
                    if (pend_wr_next) begin
                        phase_next   = PH_DROP;
                        bit_cnt_next = 6'd0;
                    end else begin
                        phase_next   = PH_RECV;
                        bit_cnt_next = {1'b0, data_w};
                    end
                end else begin
                    bit_cnt_next = bc - 6'd1;
                end
            end
            PH_RECV: begin
                cs_next       = 1'b1;
                clk_next      = 1'b1;
                busy_next     = 1'b1;
                rx_shift_next = {rx_shift_reg[14:0], s_serial_in};
                if (bc <= 6'd1) begin
                    done_next    = 1'b1;
                    phase_next   = PH_IDLE;
                    bit_cnt_next = 6'd0;
                end else begin
                    bit_cnt_next = bc - 6'd1;
                end
            end
            PH_DROP: begin
                busy_next     = 1'b1;
                phase_next    = PH_POLL;
                poll_cnt_next = 14'd0;
            end
            PH_POLL: begin
                // Ready takes priority over the timeout in the same tick.
                cs_next   = 1'b1;
                busy_next = 1'b1;
                if (s_serial_in) begin
                    done_next    = 1'b1;
                    phase_next   = PH_IDLE;
                    pend_wr_next = 1'b0;
                end else begin
                    poll_cnt_next = poll_inc;
                    if (poll_inc >= ready_timeout_reg) begin
                        done_next    = 1'b1;
                        tmo_next     = 1'b1;
                        phase_next   = PH_IDLE;
                        pend_wr_next = 1'b0;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= 6'd0;
            frame_reg    <= 32'd0;
            rx_shift_reg <= 16'd0;
            poll_cnt_reg <= 14'd0;
            pend_wr_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            cs_reg       <= 1'b0;
            clk_reg      <= 1'b0;
            di_reg       <= 1'b0;
            org_reg      <= 1'b0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            tmo_reg      <= 1'b0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            frame_reg    <= frame_next;
            rx_shift_reg <= rx_shift_next;
            poll_cnt_reg <= poll_cnt_next;
            pend_wr_reg  <= pend_wr_next;
            m_valid_reg  <= 1'b1;
            cs_reg       <= cs_next;
            clk_reg      <= clk_next;
            di_reg       <= di_next;
            org_reg      <= word_mode_reg;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            tmo_reg      <= tmo_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_chip_select = cs_reg;
    assign m_clock_pulse = clk_reg;
    assign m_data_bit    = di_reg;
    assign m_org_select  = org_reg;
    assign m_busy_res    = busy_reg;
    assign m_done_res    = done_reg;
    assign m_read_data   = rx_shift_reg;
    assign m_timed_out   = tmo_reg;

endmodule

@@ hw/rtl/mwee_checker.sv @@
// Port-level checks for microwire_eeprom_master, attached to it by the bind below.
// Depends only on the top level's ports.

module mwee_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_chip_select,
    input logic        m_clock_pulse,
    input logic        m_data_bit,
    input logic        m_busy_res,
    input logic        m_done_res,
    input logic [15:0] m_read_data,
    input logic        m_timed_out
);

    // A word held back by the sink keeps its read data, data bit and done flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_data_bit) && $stable(m_done_res))
        else $error("output word changed while stalled");

    // The input side must not accept while a stalled word occupies the output register.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted over a stalled output word");

    // Serial clock pulses only go out with chip select raised.
    a_clk_with_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clock_pulse |-> m_chip_select && m_busy_res)
        else $error("clock pulse without chip select");

    // A timeout is reported only as the end of a command.
    a_timeout_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_timed_out |-> m_done_res && m_busy_res && !m_clock_pulse)
        else $error("timeout flagged outside a finishing poll tick");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_busy_res)
        else $error("done reported while not busy");

endmodule

bind microwire_eeprom_master mwee_checker u_mwee_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_chip_select (m_chip_select),
    .m_clock_pulse (m_clock_pulse),
    .m_data_bit    (m_data_bit),
    .m_busy_res    (m_busy_res),
    .m_done_res    (m_done_res),
    .m_read_data   (m_read_data),
    .m_timed_out   (m_timed_out)
);

@@ bench/microwire_eeprom_master_test.sv @@
// Self-checking bench for microwire_eeprom_master: read and write command frames,
// ready polling and timeouts, checked word by word against a built-in predictor.
// Depends on mwee_pkg for operation codes, register indexes and chip kinds.

module microwire_eeprom_master_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int ADDR_LIMIT = 11;
    localparam int HOLD_CYCLES = 64;
    localparam int ITEM_TARGET = 400;

    typedef enum logic [2:0] {
        BUS_IDLE, BUS_EWEN, BUS_GAP, BUS_SEND, BUS_RECV, BUS_DROP, BUS_POLL
    } bus_phase_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] adr;
        logic [15:0] wdata;
        logic        si;
    } tick_t;

    typedef struct packed {
        logic        cs;
        logic        sck;
        logic        di;
        logic        org;
        logic        busy;
        logic        done;
        logic [15:0] rdata;
        logic        tmo;
    } pin_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                            cfg_wr_en = 1'b0;
    mwee_pkg::cfg_reg_t              cfg_index = mwee_pkg::REG_CHIP_KIND;
    logic [mwee_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = mwee_pkg::OP_TICK;
    logic [10:0] s_address = '0;
    logic [15:0] s_write_data = '0;
    logic        s_serial_in = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_chip_select;
    logic        m_clock_pulse;
    logic        m_data_bit;
    logic        m_org_select;
    logic        m_busy_res;
    logic        m_done_res;
    logic [15:0] m_read_data;
    logic        m_timed_out;

    microwire_eeprom_master dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_address     (s_address),
        .s_write_data  (s_write_data),
        .s_serial_in   (s_serial_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chip_select (m_chip_select),
        .m_clock_pulse (m_clock_pulse),
        .m_data_bit    (m_data_bit),
        .m_org_select  (m_org_select),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_read_data   (m_read_data),
        .m_timed_out   (m_timed_out)
    );

    always #5 aclk = ~aclk;

    // Predictor copy of the settings and of the frame state.
    logic [1:0]  cfg_kind = mwee_pkg::CHIP_93C46;
    logic        cfg_x16 = 1'b1;
    logic [13:0] cfg_tmo = mwee_pkg::READY_TIMEOUT_RESET;

    bus_phase_t  bus_ph = BUS_IDLE;
    logic [5:0]  bit_cnt = '0;
    logic [31:0] frame_bits = '0;
    logic [15:0] rx_word = '0;
    logic [13:0] poll_cnt = '0;
    logic        wr_pending = 1'b0;

    tick_t     ticks_to_send[$];
    pin_word_t pin_words_due[$];
    pin_word_t due_word;

    int mismatches = 0;
    int words_checked = 0;
    int cmds_done = 0;
    int cmds_timed_out = 0;
    int ticks_queued = 0;
    int settings_used = 1;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    int mask_age = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    tick_t cur_tick;
    tick_t nxt_tick;

    function automatic int addr_bits(logic [1:0] kind, logic x16);
        int widths_x16 [4] = '{6, 8, 7, 10};
        int w;
        w = widths_x16[kind] + (x16 ? 0 : 1);
        return (w > ADDR_LIMIT) ? ADDR_LIMIT : w;
    endfunction

    // One serial bit time of the master: pin levels, status and the read word.
    function automatic pin_word_t advance_bus(tick_t t);
        pin_word_t w;
        int a;
        int d;
        int n;
        logic [63:0] waddr;
        logic [63:0] v;
        w = '0;
        a = addr_bits(cfg_kind, cfg_x16);
        d = cfg_x16 ? 16 : 8;
        if (bus_ph == BUS_IDLE && (t.op == mwee_pkg::OP_READ || t.op == mwee_pkg::OP_WRITE)) begin
            waddr = cfg_x16 ? 64'(t.adr >> 1) : 64'(t.adr);
            waddr = waddr & ((64'd1 << a) - 64'd1);
            if (t.op == mwee_pkg::OP_READ) begin
                v = (64'(mwee_pkg::HDR_READ) << a) | waddr;
                n = 3 + a;
                rx_word = '0;
                wr_pending = 1'b0;
                bus_ph = BUS_SEND;
                bit_cnt = 6'(n);
            end else begin
                v = (((64'(mwee_pkg::HDR_WRITE) << a) | waddr) << d)
                    | 64'(cfg_x16 ? t.wdata : (t.wdata & 16'h00FF));
                n = 3 + a + d;
                wr_pending = 1'b1;
                bus_ph = BUS_EWEN;
                bit_cnt = '0;
            end
            v = v << (32 - n);
            frame_bits = v[31:0];
        end

        case (bus_ph)
            BUS_EWEN: begin
                w.cs = 1'b1;
                w.sck = 1'b1;
                w.busy = 1'b1;
                // Write-enable frame: start bit, opcode 00, then 11 and zeros.
                w.di = (bit_cnt == 6'd0 || bit_cnt == 6'd3 || bit_cnt == 6'd4);
                if (int'(bit_cnt) + 1 >= 3 + a) begin
                    bus_ph = BUS_GAP;
                    bit_cnt = '0;
                end else begin
                    bit_cnt = bit_cnt + 6'd1;
                end
            end
            BUS_GAP: begin
                w.busy = 1'b1;
                bus_ph = BUS_SEND;
                bit_cnt = 6'(3 + a + d);
            end
            BUS_SEND: begin
                w.cs = 1'b1;
                w.sck = 1'b1;
                w.busy = 1'b1;
                w.di = frame_bits[31];
                frame_bits = frame_bits << 1;
                if (bit_cnt <= 6'd1) begin
                    if (wr_pending) begin
                        bus_ph = BUS_DROP;
                        bit_cnt = '0;
                    end else begin
                        bus_ph = BUS_RECV;
                        bit_cnt = 6'(d);
                    end
                end else begin
                    bit_cnt = bit_cnt - 6'd1;
                end
            end
            BUS_RECV: begin
                w.cs = 1'b1;
                w.sck = 1'b1;
                w.busy = 1'b1;
                rx_word = {rx_word[14:0], t.si};
                if (bit_cnt <= 6'd1) begin
                    w.done = 1'b1;
                    bus_ph = BUS_IDLE;
                    bit_cnt = '0;
                end else begin
                    bit_cnt = bit_cnt - 6'd1;
                end
            end
            BUS_DROP: begin
                w.busy = 1'b1;
                bus_ph = BUS_POLL;
                poll_cnt = '0;
            end
            BUS_POLL: begin
                w.cs = 1'b1;
                w.busy = 1'b1;
                // Ready takes priority over a timeout in the same tick.
                if (t.si) begin
                    w.done = 1'b1;
                    bus_ph = BUS_IDLE;
                    wr_pending = 1'b0;
                end else begin
                    poll_cnt = poll_cnt + 14'd1;
                    if (poll_cnt >= cfg_tmo) begin
                        w.done = 1'b1;
                        w.tmo = 1'b1;
                        bus_ph = BUS_IDLE;
                        wr_pending = 1'b0;
                    end
                end
            end
            default: bus_ph = BUS_IDLE;
        endcase
        w.org = cfg_x16;
        w.rdata = rx_word;
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %h, expected %h",
                                      words_checked, name, got, want));
    endtask

    // Sender: bursts of words separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur_tick = {s_operation, s_address, s_write_data, s_serial_in};
                pin_words_due.push_back(advance_bus(cur_tick));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (ticks_to_send.size() > 0) begin
                    nxt_tick = ticks_to_send.pop_front();
                    s_operation <= nxt_tick.op;
                    s_address <= nxt_tick.adr;
                    s_write_data <= nxt_tick.wdata;
                    s_serial_in <= nxt_tick.si;
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: rotating stall mask, plus one long hold-off to back up the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held_once && words_checked >= 100) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            if (mask_age == 0) begin
                mask_age = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_mask = 16'hFFFF;
                    1: stall_mask = 16'($urandom);
                    2: stall_mask = 16'hEEEE;
                    default: stall_mask = 16'($urandom | $urandom);
                endcase
            end
            mask_age--;
            m_ready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[15:1]};
        end
    end

    // Monitor: every accepted word is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pin_words_due.size() == 0) begin
                report_mismatch("output word with no input word pending");
            end else begin
                due_word = pin_words_due.pop_front();
                check_field("chip_select", 16'(m_chip_select), 16'(due_word.cs));
                check_field("clock_pulse", 16'(m_clock_pulse), 16'(due_word.sck));
                check_field("data_bit", 16'(m_data_bit), 16'(due_word.di));
                check_field("org_select", 16'(m_org_select), 16'(due_word.org));
                check_field("busy", 16'(m_busy_res), 16'(due_word.busy));
                check_field("done", 16'(m_done_res), 16'(due_word.done));
                check_field("read_data", m_read_data, due_word.rdata);
                check_field("timed_out", 16'(m_timed_out), 16'(due_word.tmo));
                if (due_word.done)
                    cmds_done++;
                if (due_word.tmo)
                    cmds_timed_out++;
            end
            words_checked++;
        end
    end

    function automatic logic pick_si(int si_fill);
        return (si_fill < 0) ? 1'($urandom) : si_fill[0];
    endfunction

    task automatic push_tick(logic [1:0] op, logic [10:0] adr, logic [15:0] wd, logic si);
        ticks_to_send.push_back({op, adr, wd, si});
        ticks_queued++;
    endtask

    // A start word, the frame ticks under the current settings, and for a write
    // the ready poll: some busy ticks, then optionally ready.
    task automatic add_command(logic [1:0] op, logic [10:0] adr, logic [15:0] wd,
                               int si_fill, int zeros, bit ready, int noise_pct);
        int a;
        int d;
        int body;
        logic [1:0] tick_op;
        a = addr_bits(cfg_kind, cfg_x16);
        d = cfg_x16 ? 16 : 8;
        push_tick(op, adr, wd, pick_si(si_fill));
        body = (op == mwee_pkg::OP_READ) ? 2 + a + d : 2 * a + d + 7;
        for (int k = 0; k < body; k++) begin
            tick_op = ($urandom_range(0, 99) < noise_pct) ? 2'($urandom_range(1, 3))
                                                         : mwee_pkg::OP_TICK;
            push_tick(tick_op, 11'($urandom), 16'($urandom), pick_si(si_fill));
        end
        if (op == mwee_pkg::OP_WRITE) begin
            for (int k = 0; k < zeros; k++)
                push_tick(mwee_pkg::OP_TICK, 11'($urandom), 16'($urandom), 1'b0);
            if (ready)
                push_tick(mwee_pkg::OP_TICK, 11'($urandom), 16'($urandom), 1'b1);
        end
    endtask

    // Wait until every queued word has gone through and its result was checked.
    task automatic settle();
        while (ticks_to_send.size() != 0 || s_valid || pin_words_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(mwee_pkg::cfg_reg_t idx, logic [13:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mwee_pkg::REG_CHIP_KIND: cfg_kind = val[1:0];
            mwee_pkg::REG_WORD_MODE: cfg_x16 = val[0];
            default:                 cfg_tmo = val;
        endcase
    endtask

    task automatic set_config(logic [1:0] kind, logic x16, logic [13:0] tmo);
        settle();
        write_reg(mwee_pkg::REG_CHIP_KIND, 14'(kind));
        write_reg(mwee_pkg::REG_WORD_MODE, 14'(x16));
        write_reg(mwee_pkg::REG_READY_TIMEOUT, tmo);
        settings_used++;
    endtask

    initial begin
        int directed_ticks;
        int goal;
        logic [10:0] adr;
        logic [13:0] tmo;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: 93C46, x16, long timeout.
        add_command(mwee_pkg::OP_READ, 11'd0, 16'h0000, 1, 0, 1'b0, 0);
        add_command(mwee_pkg::OP_READ, 11'h7FF, 16'hFFFF, 0, 0, 1'b0, 0);
        add_command(mwee_pkg::OP_WRITE, 11'h7FF, 16'hFFFF, -1, 2, 1'b1, 0);
        push_tick(OP_SPARE, 11'h7FF, 16'hFFFF, 1'b1);
        push_tick(OP_SPARE, 11'd0, 16'h0000, 1'b0);
        // Every frame tick carries a start or the spare code, all to be ignored.
        add_command(mwee_pkg::OP_WRITE, 11'd0, 16'h0000, -1, 0, 1'b1, 100);

        // Zero timeout: the write gives up after its first busy poll tick.
        set_config(mwee_pkg::CHIP_93C76, 1'b0, 14'd0);
        add_command(mwee_pkg::OP_WRITE, 11'h7FF, 16'hFFFF, 0, 3, 1'b0, 0);
        add_command(mwee_pkg::OP_READ, 11'h7FF, 16'h0000, 1, 0, 1'b0, 0);
        // Leave a read in flight across the next settings change.
        push_tick(mwee_pkg::OP_READ, 11'h2AA, 16'h0000, 1'b0);
        repeat (5) push_tick(mwee_pkg::OP_TICK, 11'd0, 16'h0000, 1'b1);

        set_config(mwee_pkg::CHIP_93C56, 1'b1, 14'd1);
        repeat (30) push_tick(mwee_pkg::OP_TICK, 11'd0, 16'h0000, 1'($urandom));
        // Ready arrives in the tick that would also time out.
        add_command(mwee_pkg::OP_WRITE, 11'h555, 16'h1234, -1, 0, 1'b1, 0);
        add_command(mwee_pkg::OP_WRITE, 11'h2AA, 16'h8001, -1, 4, 1'b0, 0);

        // Largest timeout; ready comes after a stretch of busy polls.
        set_config(mwee_pkg::CHIP_93C57, 1'b0, 14'h3FFF);
        add_command(mwee_pkg::OP_WRITE, 11'h555, 16'hA5A5, -1, 20, 1'b1, 0);
        add_command(mwee_pkg::OP_READ, 11'h001, 16'h0000, -1, 0, 1'b0, 0);
        directed_ticks = ticks_queued;

        while (ticks_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 4))
                0: tmo = 14'd0;
                1: tmo = 14'd1;
                2: tmo = 14'h3FFF;
                3: tmo = 14'($urandom_range(1, 16383));
                default: tmo = 14'($urandom_range(2, 12));
            endcase
            set_config(2'($urandom_range(0, 3)), 1'($urandom), tmo);
            goal = ticks_queued + $urandom_range(40, 90);
            while (ticks_queued < goal) begin
                case ($urandom_range(0, 9))
                    7, 8: begin
                        repeat ($urandom_range(1, 4))
                            push_tick(2'($urandom), 11'($urandom), 16'($urandom),
                                      1'($urandom));
                    end
                    9: begin
                        // A frame cut short; the next start may land while busy.
                        push_tick(($urandom_range(0, 1) != 0) ? mwee_pkg::OP_READ
                                                              : mwee_pkg::OP_WRITE,
                                  11'($urandom), 16'($urandom), 1'($urandom));
                        repeat ($urandom_range(1, 10))
                            push_tick(mwee_pkg::OP_TICK, 11'($urandom), 16'($urandom),
                                      1'($urandom));
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: adr = 11'd0;
                            1: adr = 11'h7FF;
                            default: adr = 11'($urandom);
                        endcase
                        add_command(($urandom_range(0, 1) != 0) ? mwee_pkg::OP_READ
                                                                : mwee_pkg::OP_WRITE,
                                    adr, 16'($urandom), -1, $urandom_range(0, 12),
                                    ($urandom_range(0, 4) != 0), 5);
                    end
                endcase
            end
        end

        settle();
        repeat (5) @(posedge aclk);
        if (pin_words_due.size() != 0)
            report_mismatch("predicted words never arrived");
        $display("Ran %0d directed and %0d random input words over %0d register settings.",
                 directed_ticks, ticks_queued - directed_ticks, settings_used);
        $display("Checked %0d output words; %0d commands finished, %0d by ready timeout.",
                 words_checked, cmds_done, cmds_timed_out);
        if (mismatches == 0) begin
            $display("microwire_eeprom_master_test passed");
        end else begin
            $display("microwire_eeprom_master_test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out waiting for the run to drain.");
        $display("microwire_eeprom_master_test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mwee_pkg.sv
hw/rtl/microwire_eeprom_master.sv
hw/rtl/mwee_checker.sv
bench/microwire_eeprom_master_test.sv
